/* src/dvru_pkg.sv */
// shared types, constants and helpers for the distance-vector route update block
// no dependencies
package dvru_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;   // power of two, pointers wrap
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int ADDR_W      = 32;
    localparam int COST_W      = 8;
    localparam int RAW_W       = COST_W + 1;
    localparam int ACT_W       = 2;
    localparam int SLOT_W      = 6;
    localparam int IN_DATA_W   = 104;
    localparam int OUT_DATA_W  = 16;

    localparam logic [COST_W-1:0] INFINITY_RESET = 8'd16;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT    = 2'd0,
        ACT_UPDATE    = 2'd1,
        ACT_UNCHANGED = 2'd2,
        ACT_FULL      = 2'd3
    } dvru_action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE
    } dvru_state_t;

    // one classified advertisement waiting in the queue
    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] nbr;
        logic [ADDR_W-1:0] ifc;
        logic [RAW_W-1:0]  plus1;     // adv_cost + 1, unsaturated
        logic [RAW_W-1:0]  ins_raw;   // cost to insert before the cap
    } dvru_item_t;

    // one route table word
    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] next_hop;
        logic [ADDR_W-1:0] ifc;
        logic [COST_W-1:0] cost;
    } dvru_entry_t;

    function automatic logic [COST_W-1:0] cap_cost(input logic [RAW_W-1:0] raw,
                                                   input logic [COST_W-1:0] inf);
        cap_cost = (raw > {1'b0, inf}) ? inf : raw[COST_W-1:0];
    endfunction

endpackage

/* src/dvru_front.sv */
// front end: accepts advertisement transfers, classifies them and queues them
// depends on dvru_pkg
module dvru_front
    import dvru_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    output logic                 q_valid,
    input  logic                 q_pop,
    output dvru_item_t           q_item
);

    dvru_item_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    dvru_item_t        in_item;
    logic              push;
    logic              pop;
    logic [ADDR_W-1:0] in_dest;
    logic [COST_W-1:0] in_adv;
    logic [ADDR_W-1:0] in_nbr;

    assign in_dest = s_axis_tdata[31:0];
    assign in_adv  = s_axis_tdata[39:32];
    assign in_nbr  = s_axis_tdata[71:40];

    // classify: direct neighbor routes get an insert cost of 1 before the cap
    always_comb begin
        in_item.dest    = in_dest;
        in_item.nbr     = in_nbr;
        in_item.ifc     = s_axis_tdata[103:72];
        in_item.plus1   = {1'b0, in_adv} + RAW_W'(1);
        in_item.ins_raw = (in_nbr == in_dest) ? RAW_W'(1) : in_item.plus1;
    end

    assign s_axis_tready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (cnt_reg != '0);
    assign pop           = q_pop && q_valid;
    assign q_item        = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* src/dvru_back.sv */
// back end: linear table search, read-modify-write of the route table, result register
// depends on dvru_pkg
module dvru_back
    import dvru_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  dvru_item_t            q_item,
    input  logic [COST_W-1:0]     infinity_cost,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // route table memory, registered read port
    dvru_entry_t mem [TABLE_DEPTH];

    dvru_state_t       state_reg, state_next;
    dvru_item_t        item_reg, item_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              found_reg, found_next;
    dvru_entry_t       rd_data_reg;
    logic              out_valid_reg, out_valid_next;
    dvru_action_t      out_action_reg, out_action_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [COST_W-1:0] out_cost_reg, out_cost_next;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    dvru_entry_t       wr_data;

    logic              hit;
    logic              last;
    logic              out_free;
    logic              full;
    logic              replace;
    logic [COST_W-1:0] new_cost;

    assign hit      = (rd_data_reg.dest == item_reg.dest);
    assign last     = (({1'b0, addr_reg} + CNT_W'(1)) == count_reg);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign full     = (count_reg == CNT_W'(TABLE_DEPTH));
    assign replace  = ({1'b0, rd_data_reg.cost} > item_reg.plus1) ||
                      (rd_data_reg.next_hop == item_reg.nbr);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = (count_reg == '0) ? ST_DECIDE : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (hit || last) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = addr_reg;
        wr_en           = 1'b0;
        wr_addr         = addr_reg;
        wr_data         = rd_data_reg;
        item_next       = item_reg;
        addr_next       = addr_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_action_next = out_action_reg;
        out_slot_next   = out_slot_reg;
        out_cost_next   = out_cost_reg;
        new_cost        = cap_cost(item_reg.plus1, infinity_cost);
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    addr_next  = '0;
                    found_next = 1'b0;
                    rd_en      = (count_reg != '0);
                    rd_addr    = '0;
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    found_next = 1'b1;
                end else if (!last) begin
                    rd_en     = 1'b1;
                    rd_addr   = addr_reg + IDX_W'(1);
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (!found_reg) begin
                        if (full) begin
                            out_action_next = ACT_FULL;
                            out_slot_next   = '0;
                            out_cost_next   = infinity_cost;
                        end else begin
                            new_cost         = cap_cost(item_reg.ins_raw, infinity_cost);
                            wr_en            = 1'b1;
                            wr_addr          = count_reg[IDX_W-1:0];
                            wr_data.dest     = item_reg.dest;
                            wr_data.next_hop = item_reg.nbr;
                            wr_data.ifc      = item_reg.ifc;
                            wr_data.cost     = new_cost;
                            count_next       = count_reg + CNT_W'(1);
                            out_action_next  = ACT_INSERT;
                            out_slot_next    = SLOT_W'(count_reg[IDX_W-1:0]);
                            out_cost_next    = new_cost;
                        end
                    end else if (replace) begin
                        // interface keeps its insert-time value
                        wr_en            = 1'b1;
                        wr_addr          = addr_reg;
                        wr_data.next_hop = item_reg.nbr;
                        wr_data.cost     = new_cost;
                        out_action_next  = ACT_UPDATE;
                        out_slot_next    = SLOT_W'(addr_reg);
                        out_cost_next    = new_cost;
                    end else begin
                        out_action_next = ACT_UNCHANGED;
                        out_slot_next   = SLOT_W'(addr_reg);
                        out_cost_next   = rd_data_reg.cost;
                    end
                end
            end
            default: begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        out_action_reg <= out_action_next;
        out_slot_reg   <= out_slot_next;
        out_cost_reg   <= out_cost_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_cost_reg, out_slot_reg, out_action_reg};

endmodule

/* src/distance_vector_route_update.sv */
// the back end handles one queued item at a time: it scans slots from 0 over the single read port
// of the table memory until a hit or the last entry (no scan on an empty table), then, once the result
// register is free, writes the table and the result; only then does it pop the next item
// the two-entry input queue keeps taking transfers while the search runs, as long as it has room
// reset: entry count cleared, infinity_cost set to 16, queue and result register emptied;
// table contents stay undefined, only slots below the entry count are ever read
module distance_vector_route_update
    import dvru_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration: infinity_cost
    input  logic                  cfg_wr_en,
    input  logic [COST_W-1:0]     cfg_wr_data,
    // advertisement input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // fields from bit 0: adv_dest_address[31:0], adv_cost[39:32],
    // neighbor_address[71:40], recv_interface[103:72]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // fields from bit 0: action[1:0], slot_index[7:2], route_cost[15:8]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // cost cap; the user must write it only while idle, the block does not enforce this
    logic [COST_W-1:0] infinity_cost_reg;

    // front to back queue interface
    logic       q_valid;
    logic       q_pop;
    dvru_item_t q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            infinity_cost_reg <= INFINITY_RESET;
        end else if (cfg_wr_en) begin
            infinity_cost_reg <= cfg_wr_data;
        end
    end

    // front: takes the input transfer, precomputes cost candidates, queues the item
    dvru_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item)
    );

    // back: walks the table one slot a cycle, then inserts, updates or reports
    dvru_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item),
        .infinity_cost (infinity_cost_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* src/dvru_checker.sv */
// port-level checks for the route update block, attached by bind
// depends on dvru_pkg and distance_vector_route_update
module dvru_checker
    import dvru_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // reset empties the result register
    a_rst_out: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // reset empties the queue, so input is ready
    a_rst_in: assert property (@(posedge aclk) !aresetn |=> s_axis_tready)
        else $error("input not ready after reset");

    // a dropped route reports slot zero
    a_full_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[1:0] == ACT_FULL) |-> m_axis_tdata[7:2] == '0)
        else $error("table full result with nonzero slot");

endmodule

bind distance_vector_route_update dvru_checker u_dvru_checker (.*);

/* tb/tb_distance_vector_route_update.sv */
// self-checking testbench for distance_vector_route_update: stream stimulus with random idling
// and back-pressure, a route table predictor in a scoreboard class, and a stall watchdog
// depends on dvru_pkg and the distance_vector_route_update top level
module tb_distance_vector_route_update
    import dvru_pkg::*;
();

    localparam int HOLD_CYCLES = 400;     // long receiver hold-off, fills the input queue
    localparam int STALL_LIMIT = 20000;   // cycles without any transfer before giving up
    localparam int TAIL_CYCLES = 80;      // longer than the worst search plus write-back
    localparam int DEST_POOL   = 40;      // destinations that recur, so lookups hit
    localparam int NBR_POOL    = 4;       // neighbors that recur, so next hops match

    // route table predictor and store of expected route results
    class route_scoreboard;
        typedef struct packed {
            dvru_action_t      act;
            logic [SLOT_W-1:0] slot;
            logic [COST_W-1:0] cost;
        } route_result_t;

        logic [ADDR_W-1:0] dest_tab     [TABLE_DEPTH];
        logic [ADDR_W-1:0] next_hop_tab [TABLE_DEPTH];
        logic [ADDR_W-1:0] ifc_tab      [TABLE_DEPTH];
        logic [COST_W-1:0] cost_tab     [TABLE_DEPTH];
        int                used_slots;
        logic [COST_W-1:0] infinity;
        route_result_t     expected_q [$];
        int                errors;

        function new();
            used_slots = 0;
            infinity   = INFINITY_RESET;
            errors     = 0;
        endfunction

        function void set_infinity(input logic [COST_W-1:0] value);
            infinity = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [COST_W-1:0] saturate(input logic [RAW_W-1:0] raw);
            return (raw > {1'b0, infinity}) ? infinity : raw[COST_W-1:0];
        endfunction

        // apply one accepted advertisement to the table copy and queue its result
        function void note_advert(input logic [ADDR_W-1:0] dest, input logic [COST_W-1:0] adv,
                                  input logic [ADDR_W-1:0] nbr, input logic [ADDR_W-1:0] ifc);
            route_result_t    exp_r;
            logic [RAW_W-1:0] plus1;
            int               hit;
            plus1 = {1'b0, adv} + 9'd1;
            hit   = -1;
            for (int i = 0; i < used_slots; i++)
                if (hit < 0 && dest_tab[i] == dest)
                    hit = i;
            if (hit < 0) begin
                if (used_slots >= TABLE_DEPTH) begin
                    exp_r.act  = ACT_FULL;
                    exp_r.slot = '0;
                    exp_r.cost = infinity;
                end else begin
                    exp_r.act  = ACT_INSERT;
                    exp_r.slot = SLOT_W'(used_slots);
                    exp_r.cost = saturate((nbr == dest) ? 9'd1 : plus1);
                    dest_tab[used_slots]     = dest;
                    next_hop_tab[used_slots] = nbr;
                    ifc_tab[used_slots]      = ifc;
                    cost_tab[used_slots]     = exp_r.cost;
                    used_slots++;
                end
            end else if ({1'b0, cost_tab[hit]} > plus1 || next_hop_tab[hit] == nbr) begin
                // unsaturated compare, saturated store; interface stays as inserted
                exp_r.act          = ACT_UPDATE;
                exp_r.slot         = SLOT_W'(hit);
                exp_r.cost         = saturate(plus1);
                cost_tab[hit]      = exp_r.cost;
                next_hop_tab[hit]  = nbr;
            end else begin
                exp_r.act  = ACT_UNCHANGED;
                exp_r.slot = SLOT_W'(hit);
                exp_r.cost = cost_tab[hit];
            end
            expected_q = {expected_q, exp_r};
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(input logic [OUT_DATA_W-1:0] data);
            route_result_t     exp_r;
            logic [ACT_W-1:0]  act;
            logic [SLOT_W-1:0] slot;
            logic [COST_W-1:0] cost;
            act  = data[1:0];
            slot = data[7:2];
            cost = data[15:8];
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected, tdata %h", $time, data);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (act !== exp_r.act) begin
                $display("%0t: action expected %0d actual %0d", $time, exp_r.act, act);
                errors++;
            end
            if (slot !== exp_r.slot) begin
                $display("%0t: slot_index expected %0d actual %0d", $time, exp_r.slot, slot);
                errors++;
            end
            if (cost !== exp_r.cost) begin
                $display("%0t: route_cost expected %0d actual %0d", $time, exp_r.cost, cost);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [COST_W-1:0]     cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // fields from bit 0: adv_dest_address, adv_cost, neighbor_address, recv_interface
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // fields from bit 0: action, slot_index, route_cost
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    route_scoreboard   routes;
    int                send_idle_pct;
    int                recv_idle_pct;
    bit                hold_req;
    logic [ADDR_W-1:0] dest_pool [DEST_POOL];
    logic [ADDR_W-1:0] nbr_pool  [NBR_POOL];

    distance_vector_route_update u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random back-pressure, plus a long hold-off on request
    initial begin : result_sink
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // every result transfer goes straight to the scoreboard
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            routes.check_result(m_axis_tdata);
    end

    // stall watchdog: counts cycles in which neither side moves a transfer
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL distance_vector_route_update");
        $finish;
    end

    // offer one advertisement, with random idle cycles ahead of it, until accepted
    task automatic send_advert(input logic [ADDR_W-1:0] dest, input logic [COST_W-1:0] adv,
                               input logic [ADDR_W-1:0] nbr, input logic [ADDR_W-1:0] ifc);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ifc, nbr, adv, dest};
        do
            @(posedge aclk);
        while (!s_axis_tready);
        routes.note_advert(dest, adv, nbr, ifc);
    endtask

    // stop offering and wait until every expected result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (routes.pending() != 0)
            @(posedge aclk);
        // each item gives a result, so the block is idle now; the spare wait below is only a margin
        repeat (4) @(posedge aclk);
    endtask

    // only called with the block drained
    task automatic write_infinity(input logic [COST_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        routes.set_infinity(value);
    endtask

    // one random stretch: mostly recurring destinations and neighbors so lookups hit and
    // next hops match, some fresh ones that fill the table and then get dropped
    task automatic random_phase(input logic [COST_W-1:0] inf, input int snd_pct,
                                input int rcv_pct, input int items, input bit hold,
                                input bit pause);
        logic [ADDR_W-1:0] dest;
        logic [COST_W-1:0] adv;
        logic [ADDR_W-1:0] nbr;
        int                pick;
        write_infinity(inf);
        send_idle_pct = snd_pct;
        recv_idle_pct <= rcv_pct;
        if (hold)
            hold_req <= ~hold_req;
        for (int k = 0; k < items; k++) begin
            if (pause && k == items / 2)
                drain_results();
            dest = ($urandom_range(0, 99) < 85) ? dest_pool[$urandom_range(0, DEST_POOL - 1)]
                                                : $urandom();
            adv  = ($urandom_range(0, 99) < 60) ? COST_W'($urandom_range(0, 20))
                                                : COST_W'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 70)
                nbr = nbr_pool[$urandom_range(0, NBR_POOL - 1)];
            else if (pick < 80)
                nbr = dest;
            else
                nbr = $urandom();
            send_advert(dest, adv, nbr, $urandom());
        end
        drain_results();
    endtask

    initial begin : main
        routes        = new();
        send_idle_pct = 9;
        recv_idle_pct <= 78;
        hold_req      <= 1'b0;
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        for (int i = 0; i < DEST_POOL; i++)
            dest_pool[i] = $urandom();
        for (int i = 0; i < NBR_POOL; i++)
            nbr_pool[i] = $urandom();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, default infinity of 16
        send_advert(32'h0A00_0001, 8'd2, 32'h0B00_0001, 32'h0000_0000);    // plain insert
        send_advert(32'h0B00_0002, 8'd200, 32'h0B00_0002, 32'hC0A8_0001);  // neighbor is dest
        send_advert(32'h0A00_0001, 8'd0, 32'h0B00_0002, 32'h1111_1111);    // lower cost wins
        send_advert(32'h0A00_0001, 8'd9, 32'h0B00_0002, 32'h2222_2222);    // same hop, worse
        send_advert(32'h0A00_0001, 8'd20, 32'h0B00_0001, 32'h3333_3333);   // left alone
        send_advert(32'hFFFF_FFFF, 8'd255, 32'h0000_0000, 32'hFFFF_FFFF);  // insert capped
        send_advert(32'hFFFF_FFFF, 8'd255, 32'h0000_0000, 32'h0000_0001);  // 9-bit compare
        send_advert(32'hFFFF_FFFF, 8'd255, 32'h0B00_0001, 32'h0000_0002);  // 256 never lower
        send_advert(32'h0000_0000, 8'd14, 32'h0B00_0001, 32'h0000_0003);
        send_advert(32'h0000_0000, 8'd15, 32'h0B00_0003, 32'h0000_0004);   // equal to inf
        send_advert(32'h0000_0000, 8'd13, 32'h0B00_0003, 32'h0000_0005);   // just lower
        send_advert(32'h0000_0000, 8'd13, 32'h0B00_0001, 32'h0000_0006);   // tie keeps hop
        drain_results();

        // zero infinity flattens every written cost
        write_infinity(8'd0);
        send_advert(32'h0A00_0001, 8'd0, 32'h0B00_0002, 32'h5555_5555);
        send_advert(32'h0D00_0004, 8'd7, 32'h0D00_0004, 32'hAAAA_AAAA);
        send_advert(32'h0D00_0004, 8'd0, 32'h0B00_0003, 32'h0F0F_0F0F);
        drain_results();

        // top infinity
        write_infinity(8'd255);
        send_advert(32'h0B00_0002, 8'd254, 32'h0B00_0002, 32'h0000_0007);
        send_advert(32'h0B00_0002, 8'd255, 32'h0B00_0002, 32'h0000_0008);
        send_advert(32'h0E00_0005, 8'd254, 32'h0B00_0001, 32'h0000_0009);
        drain_results();

        // smallest legal infinity
        write_infinity(8'd1);
        send_advert(32'h0F00_0006, 8'd5, 32'h0B00_0001, 32'h0000_000A);
        send_advert(32'h0F00_0006, 8'd0, 32'h0B00_0003, 32'h0000_000B);
        drain_results();

        // sender rarely idle, receiver mostly stalled; one long hold-off fills the queue
        random_phase(8'd255, 9, 78, 310, 1'b1, 1'b0);
        random_phase(8'd5, 9, 78, 310, 1'b0, 1'b0);
        // the other way round, the first with a pause in the middle until all results are back
        random_phase(8'd16, 78, 9, 310, 1'b0, 1'b1);
        random_phase(8'd1, 78, 9, 310, 1'b0, 1'b0);
        // no idling at all
        random_phase(8'd255, 0, 0, 310, 1'b1, 1'b0);
        random_phase(8'd32, 0, 0, 310, 1'b0, 1'b0);

        // quiet tail: anything that shows up now has no expectation
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (routes.pending() != 0) begin
            $display("%0t: %0d results never arrived", $time, routes.pending());
            routes.errors++;
        end
        if (routes.errors == 0)
            $display("PASS distance_vector_route_update");
        else
            $display("FAIL distance_vector_route_update");
        $finish;
    end

endmodule

/* distance_vector_route_update.f */
src/dvru_pkg.sv
src/dvru_front.sv
src/dvru_back.sv
src/distance_vector_route_update.sv
src/dvru_checker.sv
tb/tb_distance_vector_route_update.sv
